### rtl/cdd_pkg.sv
// Shared constants, codes and types of the clock drift discipline block.
package cdd_pkg;

  // Field widths.
  localparam int SEC_W      = 32;
  localparam int USEC_W     = 20;
  localparam int LAT_W      = 10;
  localparam int PREC_W     = 10;
  localparam int DRIFT_W    = 43;
  localparam int AVG_W      = 15;
  localparam int SLEW_SEC_W = 5;
  localparam int SAMP_W     = 10;
  localparam int ACTION_W   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE = CFG_IDX_W'(1);
  localparam logic [PREC_W-1:0]    PREC_RESET    = PREC_W'(10);

  // Learning window.
  localparam int LEARN_WINDOW   = 10;
  localparam int FORCE_LIMIT_MS = 10000;
  localparam int WIN_W          = $clog2(LEARN_WINDOW + 1);
  localparam int ACC_W          = $clog2(LEARN_WINDOW * FORCE_LIMIT_MS) + 1;

  // Sync period average.
  localparam int GAP_W      = 10;
  localparam int GAP_MAX    = 1000;
  localparam int GAP_SCALE  = 100;
  localparam int PSUM_W     = 18;
  localparam int PSUM_HALVE = 20000;
  localparam int PCNT_W     = 12;
  localparam int PCNT_STEP  = 10;
  localparam int PCNT_MAX   = 4090;
  localparam int ROUND_DIV  = 10;
  localparam int ROUND_HALF = 5;
  localparam int SAMP_MAX   = 1000;

  // Time units.
  localparam int MS_PER_SEC    = 1000;
  localparam int USEC_PER_MS   = 1000;
  localparam int USEC_PER_SEC  = 1000000;
  localparam int UNSYNC_FACTOR = 50;
  localparam int SET_US_W      = USEC_W + 2;
  localparam int USQ_W         = 12;
  localparam int PREC50_W      = PREC_W + 6;
  localparam int SLEW_REM_W    = 10;

  // Shared divider: two quotient bits per cycle.
  localparam int DVD_W          = 20;
  localparam int DVS_W          = 12;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYC        = DVD_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_CYC + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_SET  = 2'd1,
    ACT_SLEW = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUS_GO,
    ST_DUS_WAIT,
    ST_DRIFT,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_RND_GO,
    ST_RND_WAIT,
    ST_DECIDE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_JUDGE,
    ST_SLEW_GO,
    ST_SLEW_WAIT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

### rtl/cdd_ifs.sv
// Channel interfaces of the clock drift discipline block: item, result and configuration.
interface cdd_item_if;
  import cdd_pkg::*;
  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  source_sec;
  logic [USEC_W-1:0] source_usec;
  logic [SEC_W-1:0]  local_sec;
  logic [USEC_W-1:0] local_usec;
  logic [LAT_W-1:0]  latency_ms;
  logic [SEC_W-1:0]  now_sec;

  modport source (output valid, source_sec, source_usec, local_sec, local_usec,
                  latency_ms, now_sec, input ready);
  modport sink (input valid, source_sec, source_usec, local_sec, local_usec,
                latency_ms, now_sec, output ready);
endinterface

interface cdd_result_if;
  import cdd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic [SEC_W-1:0]             set_sec;
  logic [USEC_W-1:0]            set_usec;
  logic signed [SLEW_SEC_W-1:0] slew_sec;
  logic [USEC_W-1:0]            slew_usec;
  logic signed [DRIFT_W-1:0]    drift_ms;
  logic signed [AVG_W-1:0]      avg_drift_ms;
  logic                         in_sync;
  logic [SAMP_W-1:0]            sampling_s;

  modport source (output valid, action, set_sec, set_usec, slew_sec, slew_usec,
                  drift_ms, avg_drift_ms, in_sync, sampling_s, input ready);
  modport sink (input valid, action, set_sec, set_usec, slew_sec, slew_usec,
                drift_ms, avg_drift_ms, in_sync, sampling_s, output ready);
endinterface

interface cdd_cfg_if;
  import cdd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/cdd_div.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
module cdd_div (
  input  logic              clk,
  input  logic              rst,
  input  cdd_pkg::div_req_t req,
  output cdd_pkg::div_rsp_t rsp
);
  import cdd_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     quo;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DVD_W-1:0]     quo_next;
  logic [DVS_W-1:0]     rem_next;
  logic [DVS_W:0]       trial;

  // The dividend shifts out of the top of quo while quotient bits enter at the bottom.
  always_comb begin
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial = {rem_next, quo_next[DVD_W-1]};
      if (trial >= {1'b0, dvs}) begin
        rem_next = DVS_W'(trial - {1'b0, dvs});
        quo_next = {quo_next[DVD_W-2:0], 1'b1};
      end else begin
        rem_next = trial[DVS_W-1:0];
        quo_next = {quo_next[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_CYC);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### rtl/clock_drift_discipline_core.sv
// Clock drift discipline: one time stamp pair in, one set/slew/no-change decision out.
//
// Each accepted item produces exactly one result beat. An item occupies the block for
// the shortest time on the first call and the longest at the end of a learning window
// with slew; the shared divider is used up to five times per item (microsecond
// difference, period average, rounding, window average, slew split). The item port is
// ready only while the sequencer is idle, and a finished result waits in an output
// register, so the next item can be taken before the previous result is read.
// Configuration writes are always accepted and must be made only while the block is idle.
module clock_drift_discipline_core (
  input logic          clk,
  input logic          rst,
  cdd_item_if.sink     item,
  cdd_result_if.source result,
  cdd_cfg_if.sink      cfg
);
  import cdd_pkg::*;

  seq_state_t state, state_next;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic item_acc, cfg_acc, out_load;

  // Configuration and persistent state.
  logic [PREC_W-1:0]       prec;
  logic                    test_mode;
  logic                    seen_call;
  logic [SEC_W-1:0]        last_call_second;
  logic [PSUM_W-1:0]       period_sum;
  logic [PCNT_W-1:0]       period_count;
  logic signed [ACC_W-1:0] drift_accum;
  logic [WIN_W-1:0]        window_count;
  logic                    sync_flag;
  logic [SAMP_W-1:0]       sampling_reg;
  logic signed [AVG_W-1:0] avg_drift_reg;

  // Per-item working registers.
  logic                      first;
  logic signed [SEC_W:0]     sec_diff;
  logic signed [USEC_W:0]    dus;
  logic [SEC_W-1:0]          src_sec;
  logic [USEC_W-1:0]         src_usec;
  logic [LAT_W-1:0]          lat;
  logic [GAP_W-1:0]          gap;
  logic signed [DRIFT_W-1:0] prod;
  logic [SET_US_W-1:0]       set_us;
  logic signed [USQ_W-1:0]   usq;
  logic signed [DRIFT_W-1:0] drift;
  logic [DVD_W-1:0]          per_avg;

  action_t                      res_action;
  logic [SEC_W-1:0]             res_set_sec;
  logic [USEC_W-1:0]            res_set_usec;
  logic signed [SLEW_SEC_W-1:0] res_slew_sec;
  logic [USEC_W-1:0]            res_slew_usec;

  // Output register.
  logic                         out_valid;
  action_t                      out_action;
  logic [SEC_W-1:0]             out_set_sec;
  logic [USEC_W-1:0]            out_set_usec;
  logic signed [SLEW_SEC_W-1:0] out_slew_sec;
  logic [USEC_W-1:0]            out_slew_usec;
  logic signed [DRIFT_W-1:0]    out_drift;
  logic signed [AVG_W-1:0]      out_avg;
  logic                         out_sync;
  logic [SAMP_W-1:0]            out_samp;

  // Combinational helpers.
  logic signed [SEC_W:0]     gap_diff;
  logic [GAP_W-1:0]          gap_clamped;
  logic [USEC_W:0]           dus_mag;
  logic                      halve;
  logic [PSUM_W-1:0]         sum_h;
  logic [PCNT_W-1:0]         cnt_h;
  logic [PSUM_W-1:0]         psum_next;
  logic [PCNT_W:0]           pcnt_wide;
  logic [PCNT_W-1:0]         pcnt_next;
  logic signed [DRIFT_W-1:0] sd_ext;
  logic signed [DRIFT_W-1:0] prod_next;
  logic [SET_US_W-1:0]       set_us_next;
  logic signed [USQ_W-1:0]   usq_mag;
  logic signed [USQ_W-1:0]   usq_next;
  logic signed [DRIFT_W-1:0] usq_ext;
  logic signed [DRIFT_W-1:0] lat_ext;
  logic signed [DRIFT_W-1:0] drift_next;
  logic [DVD_W:0]            samp_wide;
  logic [SAMP_W-1:0]         samp_next;
  logic [DRIFT_W-1:0]        drift_mag;
  logic                      force_set;
  logic [SET_US_W-1:0]       us_adj;
  logic [1:0]                carry;
  logic signed [ACC_W-1:0]   drift_low;
  logic signed [ACC_W-1:0]   acc_sum;
  logic [WIN_W-1:0]          win_sum;
  logic                      window_open;
  logic [ACC_W-1:0]          acc_mag;
  logic signed [AVG_W-1:0]   avg_mag;
  logic signed [AVG_W-1:0]   avg_next;
  logic [AVG_W-1:0]          absa;
  logic [PREC50_W-1:0]       absa_ext;
  logic [PREC50_W-1:0]       prec_ext;
  logic [PREC50_W-1:0]       prec50;
  logic signed [SLEW_SEC_W-1:0] sq_s;
  logic [SLEW_REM_W-1:0]        slew_rem;
  logic signed [SLEW_SEC_W-1:0] slew_sec_next;
  logic [USEC_W-1:0]            slew_usec_next;

  cdd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign item_acc = item.valid && item.ready;
  assign cfg_acc  = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;

  // Gap since the previous call, clamped to the range the average can take.
  assign gap_diff = $signed({1'b0, item.now_sec}) - $signed({1'b0, last_call_second});
  always_comb begin
    if (gap_diff[SEC_W]) begin
      gap_clamped = '0;
    end else if (gap_diff[SEC_W-1:0] > SEC_W'(GAP_MAX)) begin
      gap_clamped = GAP_W'(GAP_MAX);
    end else begin
      gap_clamped = gap_diff[GAP_W-1:0];
    end
  end

  assign dus_mag = dus[USEC_W] ? (USEC_W + 1)'(-dus) : (USEC_W + 1)'(dus);

  // Period average update; both sums halve together once the sum gets large.
  assign halve     = period_sum >= PSUM_W'(PSUM_HALVE);
  assign sum_h     = halve ? (period_sum >> 1) : period_sum;
  assign cnt_h     = halve ? (period_count >> 1) : period_count;
  assign psum_next = sum_h + PSUM_W'(gap) * PSUM_W'(GAP_SCALE);
  assign pcnt_wide = {1'b0, cnt_h} + (PCNT_W + 1)'(PCNT_STEP);
  assign pcnt_next = (pcnt_wide > (PCNT_W + 1)'(PCNT_MAX)) ? PCNT_W'(PCNT_MAX)
                                                           : pcnt_wide[PCNT_W-1:0];

  // Seconds difference times 1000 as 1024 - 16 - 8.
  assign sd_ext      = sec_diff;
  assign prod_next   = (sd_ext <<< 10) - (sd_ext <<< 4) - (sd_ext <<< 3);
  assign set_us_next = SET_US_W'(src_usec) + SET_US_W'(lat) * SET_US_W'(USEC_PER_MS);

  assign usq_mag  = {1'b0, div_rsp.quotient[USQ_W-2:0]};
  assign usq_next = dus[USEC_W] ? -usq_mag : usq_mag;

  assign usq_ext    = usq;
  assign lat_ext    = {{(DRIFT_W - LAT_W){1'b0}}, lat};
  assign drift_next = prod + usq_ext + lat_ext;

  // Round the period average to whole seconds, half up, with a floor of one second and a ceiling of 1000.
  assign samp_wide = {1'b0, div_rsp.quotient}
                   + (DVD_W + 1)'(div_rsp.remainder >= DVS_W'(ROUND_HALF));
  always_comb begin
    if (per_avg < DVD_W'(ROUND_DIV)) begin
      samp_next = SAMP_W'(1);
    end else if (samp_wide > (DVD_W + 1)'(SAMP_MAX)) begin
      samp_next = SAMP_W'(SAMP_MAX);
    end else begin
      samp_next = samp_wide[SAMP_W-1:0];
    end
  end

  assign drift_mag = drift[DRIFT_W-1] ? DRIFT_W'(-drift) : DRIFT_W'(drift);
  assign force_set = first || (drift_mag >= DRIFT_W'(FORCE_LIMIT_MS));

  always_comb begin
    if (set_us >= SET_US_W'(2 * USEC_PER_SEC)) begin
      carry  = 2'd2;
      us_adj = set_us - SET_US_W'(2 * USEC_PER_SEC);
    end else if (set_us >= SET_US_W'(USEC_PER_SEC)) begin
      carry  = 2'd1;
      us_adj = set_us - SET_US_W'(USEC_PER_SEC);
    end else begin
      carry  = 2'd0;
      us_adj = set_us;
    end
  end

  assign drift_low   = drift[ACC_W-1:0];
  assign acc_sum     = drift_accum + drift_low;
  assign win_sum     = window_count + WIN_W'(1);
  assign window_open = (lat != '0) && (win_sum < WIN_W'(LEARN_WINDOW));

  assign acc_mag  = drift_accum[ACC_W-1] ? ACC_W'(-drift_accum) : ACC_W'(drift_accum);
  assign avg_mag  = {1'b0, div_rsp.quotient[AVG_W-2:0]};
  assign avg_next = drift_accum[ACC_W-1] ? -avg_mag : avg_mag;

  assign absa     = avg_drift_reg[AVG_W-1] ? AVG_W'(-avg_drift_reg) : AVG_W'(avg_drift_reg);
  assign absa_ext = PREC50_W'(absa);
  assign prec_ext = PREC50_W'(prec);
  assign prec50   = prec_ext * PREC50_W'(UNSYNC_FACTOR);

  // Slew split: microseconds stay non-negative by borrowing one second.
  assign sq_s     = {1'b0, div_rsp.quotient[SLEW_SEC_W-2:0]};
  assign slew_rem = div_rsp.remainder[SLEW_REM_W-1:0];
  always_comb begin
    if (!avg_drift_reg[AVG_W-1]) begin
      slew_sec_next  = sq_s;
      slew_usec_next = USEC_W'(slew_rem) * USEC_W'(USEC_PER_MS);
    end else if (slew_rem == '0) begin
      slew_sec_next  = -sq_s;
      slew_usec_next = '0;
    end else begin
      slew_sec_next  = -(sq_s + SLEW_SEC_W'(1));
      slew_usec_next = (USEC_W'(MS_PER_SEC) - USEC_W'(slew_rem)) * USEC_W'(USEC_PER_MS);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (item_acc) state_next = ST_DUS_GO;
      ST_DUS_GO:    state_next = ST_DUS_WAIT;
      ST_DUS_WAIT:  if (div_rsp.done) state_next = ST_DRIFT;
      ST_DRIFT:     state_next = first ? ST_DECIDE : ST_PER_GO;
      ST_PER_GO:    state_next = ST_PER_WAIT;
      ST_PER_WAIT:  if (div_rsp.done) state_next = ST_RND_GO;
      ST_RND_GO:    state_next = ST_RND_WAIT;
      ST_RND_WAIT:  if (div_rsp.done) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (test_mode || force_set || window_open) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO:    state_next = ST_AVG_WAIT;
      ST_AVG_WAIT:  if (div_rsp.done) state_next = ST_JUDGE;
      ST_JUDGE:     state_next = (absa_ext < prec_ext) ? ST_DONE : ST_SLEW_GO;
      ST_SLEW_GO:   state_next = ST_SLEW_WAIT;
      ST_SLEW_WAIT: if (div_rsp.done) state_next = ST_DONE;
      ST_DONE:      if (!out_valid || result.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: item ready, divider operands, result load.
  always_comb begin
    item.ready       = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      ST_IDLE: item.ready = 1'b1;
      ST_DUS_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = dus_mag[USEC_W-1:0];
        div_req.divisor  = DVS_W'(USEC_PER_MS);
      end
      ST_PER_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(period_sum);
        div_req.divisor  = DVS_W'(period_count);
      end
      ST_RND_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = per_avg;
        div_req.divisor  = DVS_W'(ROUND_DIV);
      end
      ST_AVG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(acc_mag);
        div_req.divisor  = DVS_W'(window_count);
      end
      ST_SLEW_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(absa);
        div_req.divisor  = DVS_W'(MS_PER_SEC);
      end
      ST_DONE: out_load = !out_valid || result.ready;
      default: ;
    endcase
  end

  // Control and persistent state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      prec             <= PREC_RESET;
      test_mode        <= 1'b0;
      seen_call        <= 1'b0;
      last_call_second <= '0;
      period_sum       <= '0;
      period_count     <= '0;
      drift_accum      <= '0;
      window_count     <= '0;
      sync_flag        <= 1'b0;
      sampling_reg     <= '0;
      avg_drift_reg    <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        case (cfg.index)
          REG_PRECISION: prec      <= cfg.data[PREC_W-1:0];
          REG_TEST_MODE: test_mode <= cfg.data[0];
          default: ;
        endcase
      end
      if (item_acc) begin
        seen_call        <= 1'b1;
        last_call_second <= item.now_sec;
      end
      if (state == ST_DUS_GO && !first) begin
        period_sum   <= psum_next;
        period_count <= pcnt_next;
      end
      if (state == ST_RND_WAIT && div_rsp.done) begin
        sampling_reg <= samp_next;
      end
      if (state == ST_DECIDE) begin
        if (test_mode) begin
          sync_flag <= drift_mag < DRIFT_W'(prec);
        end else if (force_set) begin
          sync_flag    <= 1'b1;
          drift_accum  <= '0;
          window_count <= '0;
        end else begin
          drift_accum  <= acc_sum;
          window_count <= win_sum;
        end
      end
      if (state == ST_AVG_WAIT && div_rsp.done) begin
        avg_drift_reg <= avg_next;
        drift_accum   <= '0;
        window_count  <= '0;
      end
      if (state == ST_JUDGE) begin
        if (absa_ext < prec_ext) begin
          sync_flag <= 1'b1;
        end else if (absa_ext > prec50) begin
          sync_flag <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-item working values and the output register payload.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      first         <= !seen_call;
      sec_diff      <= $signed({1'b0, item.source_sec}) - $signed({1'b0, item.local_sec});
      dus           <= $signed({1'b0, item.source_usec}) - $signed({1'b0, item.local_usec});
      src_sec       <= item.source_sec;
      src_usec      <= item.source_usec;
      lat           <= item.latency_ms;
      gap           <= gap_clamped;
      res_action    <= ACT_NONE;
      res_set_sec   <= '0;
      res_set_usec  <= '0;
      res_slew_sec  <= '0;
      res_slew_usec <= '0;
    end
    if (state == ST_DUS_GO) begin
      prod   <= prod_next;
      set_us <= set_us_next;
    end
    if (state == ST_DUS_WAIT && div_rsp.done) begin
      usq <= usq_next;
    end
    if (state == ST_DRIFT) begin
      drift <= drift_next;
    end
    if (state == ST_PER_WAIT && div_rsp.done) begin
      per_avg <= div_rsp.quotient;
    end
    if (state == ST_DECIDE && !test_mode && force_set) begin
      res_action   <= ACT_SET;
      res_set_sec  <= src_sec + SEC_W'(carry);
      res_set_usec <= us_adj[USEC_W-1:0];
    end
    if (state == ST_SLEW_WAIT && div_rsp.done) begin
      res_action    <= ACT_SLEW;
      res_slew_sec  <= slew_sec_next;
      res_slew_usec <= slew_usec_next;
    end
    if (out_load) begin
      out_action    <= res_action;
      out_set_sec   <= res_set_sec;
      out_set_usec  <= res_set_usec;
      out_slew_sec  <= res_slew_sec;
      out_slew_usec <= res_slew_usec;
      out_drift     <= drift;
      out_avg       <= avg_drift_reg;
      out_sync      <= sync_flag;
      out_samp      <= sampling_reg;
    end
  end

  assign result.valid        = out_valid;
  assign result.action       = out_action;
  assign result.set_sec      = out_set_sec;
  assign result.set_usec     = out_set_usec;
  assign result.slew_sec     = out_slew_sec;
  assign result.slew_usec    = out_slew_usec;
  assign result.drift_ms     = out_drift;
  assign result.avg_drift_ms = out_avg;
  assign result.in_sync      = out_sync;
  assign result.sampling_s   = out_samp;

endmodule

### rtl/cdd_checker.sv
// Port-level checks of the clock drift discipline core, bound into that core.
module cdd_port_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    item_valid,
  input logic                                    item_ready,
  input logic                                    res_valid,
  input logic                                    res_ready,
  input logic [cdd_pkg::ACTION_W-1:0]            res_action,
  input logic [cdd_pkg::SEC_W-1:0]               res_set_sec,
  input logic [cdd_pkg::USEC_W-1:0]              res_set_usec,
  input logic signed [cdd_pkg::SLEW_SEC_W-1:0]   res_slew_sec,
  input logic [cdd_pkg::USEC_W-1:0]              res_slew_usec,
  input logic                                    res_in_sync,
  input logic signed [cdd_pkg::DRIFT_W-1:0]      res_drift
);
  import cdd_pkg::*;

  // The sequencer holds one item at a time, so ready drops right after a beat.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while sequencer busy");

  a_set_only_on_force: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_action != ACT_SET |-> res_set_sec == '0 && res_set_usec == '0)
    else $error("set fields nonzero without a force");

  a_force_syncs: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_action == ACT_SET |-> res_in_sync && res_set_usec < USEC_W'(USEC_PER_SEC))
    else $error("force beat not normalized or not in sync");

  a_slew_only_on_slew: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_action != ACT_SLEW |-> res_slew_sec == '0 && res_slew_usec == '0)
    else $error("slew fields nonzero without a slew");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_drift))
    else $error("stalled result beat changed");

endmodule

bind clock_drift_discipline_core cdd_port_checker u_cdd_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_action    (result.action),
  .res_set_sec   (result.set_sec),
  .res_set_usec  (result.set_usec),
  .res_slew_sec  (result.slew_sec),
  .res_slew_usec (result.slew_usec),
  .res_in_sync   (result.in_sync),
  .res_drift     (result.drift_ms)
);
